// ===== sv/tls13sh_pkg.sv =====
// Package for the ServerHello parser: request and result types,
// byte kind codes and protocol constants. No dependencies.
package tls13sh_pkg;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_RANDOM = 2'd1,
        KIND_KEY    = 2'd2
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } req_t;

    typedef struct packed {
        byte_kind_t byte_kind;
        logic [7:0] field_byte;
        logic [4:0] field_index;
        logic       verdict_valid;
        logic       accepted;
    } result_t;

    localparam logic [7:0]  HS_SERVER_HELLO        = 8'h02;
    localparam logic [7:0]  LEGACY_VER_BYTE        = 8'h03;
    localparam logic [7:0]  TLS13_MINOR            = 8'h04;
    localparam logic [7:0]  CIPHER_HI              = 8'h13;
    localparam logic [7:0]  CIPHER_LO              = 8'h01;
    localparam logic [7:0]  COMP_COUNT             = 8'h01;
    localparam logic [7:0]  COMP_NULL              = 8'h00;
    localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'h002b;
    localparam logic [15:0] EXT_KEY_SHARE          = 16'h0033;
    localparam logic [15:0] GROUP_X25519           = 16'h001d;
    localparam logic [15:0] FIELD_LEN              = 16'd32;
    localparam logic [15:0] SHARE_HDR_LEN          = 16'd4;
    localparam logic [15:0] SV_BODY_LEN            = 16'd2;
    localparam logic [15:0] EXT_HDR_LEN            = 16'd4;
    localparam logic [15:0] HDR_LEN                = 16'd4;
    localparam logic [23:0] MAX_DECL_LEN           = 24'd65531;
    localparam logic [15:0] POS_SATURATED          = 16'hFFFF;

endpackage

// ===== sv/tls13sh_in_stage.sv =====
// Input register for message bytes.
// Depends on tls13sh_pkg.
module tls13sh_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tls13sh_pkg::req_t   req_in,
    input  logic                out_free,
    output logic                req_valid,
    output tls13sh_pkg::req_t   req_out
);
    import tls13sh_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    req_t req_reg;
    logic load;

    assign load          = !in_valid_reg || out_free;
    assign byte_stall    = !load;
    assign in_valid_next = load ? byte_valid : in_valid_reg;
    assign req_valid     = in_valid_reg;
    assign req_out       = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && byte_valid)
        begin
            req_reg <= req_in;
        end
    end

endmodule

// ===== sv/tls13sh_parse_core.sv =====
// Byte-serial ServerHello parser: state registers and next-state logic.
// Depends on tls13sh_pkg.
module tls13sh_parse_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  tls13sh_pkg::req_t      req,
    output tls13sh_pkg::result_t   res
);
    import tls13sh_pkg::*;

    typedef enum logic [25:0] {
        PH_TYPE    = 26'h0000001,
        PH_LEN0    = 26'h0000002,
        PH_LEN1    = 26'h0000004,
        PH_LEN2    = 26'h0000008,
        PH_VER0    = 26'h0000010,
        PH_VER1    = 26'h0000020,
        PH_RANDOM  = 26'h0000040,
        PH_SIDLEN  = 26'h0000080,
        PH_SIDSKIP = 26'h0000100,
        PH_CS0     = 26'h0000200,
        PH_CS1     = 26'h0000400,
        PH_COMPLEN = 26'h0000800,
        PH_COMP    = 26'h0001000,
        PH_EXTLEN0 = 26'h0002000,
        PH_EXTLEN1 = 26'h0004000,
        PH_ET0     = 26'h0008000,
        PH_ET1     = 26'h0010000,
        PH_ES0     = 26'h0020000,
        PH_ES1     = 26'h0040000,
        PH_SV0     = 26'h0080000,
        PH_SV1     = 26'h0100000,
        PH_KSH     = 26'h0200000,
        PH_KEY     = 26'h0400000,
        PH_SKIP    = 26'h0800000,
        PH_DONE    = 26'h1000000,
        PH_SINK    = 26'h2000000
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [23:0] declared_length_reg, declared_length_next;
    logic [15:0] field_remaining_reg, field_remaining_next;
    logic [15:0] ext_kind_reg, ext_kind_next;
    logic [15:0] ext_length_reg, ext_length_next;
    logic [15:0] ext_area_reg, ext_area_next;
    logic [31:0] share_header_reg, share_header_next;
    logic        seen_version_reg, seen_version_next;
    logic        seen_key_share_reg, seen_key_share_next;
    logic        type_is_hello_reg, type_is_hello_next;
    logic        failed_reg, failed_next;

    logic [7:0]  b;
    logic        sat_fail;
    logic        len_fail;
    logic        fail;
    logic [24:0] decl_plus_hdr;
    logic [15:0] area_dec;
    logic [15:0] body_dec;
    logic [15:0] field_dec;
    logic [15:0] area_full;
    logic [15:0] area_expected;
    logic [15:0] ext_len_full;
    logic [23:0] decl_shift;
    logic [31:0] share_shift;

    function automatic phase_t next_ext(input logic [15:0] area);
        phase_t p;
        begin
            p = PH_ET0;
            if (area == 16'd0)
            begin
                p = PH_DONE;
            end
            else if (area < EXT_HDR_LEN)
            begin
                p = PH_SINK;
            end
            next_ext = p;
        end
    endfunction

    always_comb
    begin
        b             = req.data_byte;
        decl_plus_hdr = {1'b0, declared_length_reg} + {9'd0, HDR_LEN};
        area_dec      = (ext_area_reg != 16'd0) ? ext_area_reg - 16'd1 : ext_area_reg;
        body_dec      = (ext_length_reg != 16'd0) ? ext_length_reg - 16'd1 : ext_length_reg;
        field_dec     = field_remaining_reg - 16'd1;
        area_full     = {ext_area_reg[15:8], b};
        area_expected = declared_length_reg[15:0] + (HDR_LEN - 16'd1) - byte_position_reg;
        ext_len_full  = {ext_length_reg[15:8], b};
        decl_shift    = {declared_length_reg[15:0], b};
        share_shift   = {share_header_reg[23:0], b};

        phase_next           = phase_reg;
        byte_position_next   = byte_position_reg;
        declared_length_next = declared_length_reg;
        field_remaining_next = field_remaining_reg;
        ext_kind_next        = ext_kind_reg;
        ext_length_next      = ext_length_reg;
        ext_area_next        = ext_area_reg;
        share_header_next    = share_header_reg;
        seen_version_next    = seen_version_reg;
        seen_key_share_next  = seen_key_share_reg;
        type_is_hello_next   = type_is_hello_reg;
        fail                 = 1'b0;

        res.byte_kind     = KIND_NONE;
        res.field_byte    = 8'd0;
        res.field_index   = 5'd0;
        res.verdict_valid = req.end_of_message;
        res.accepted      = 1'b0;

        sat_fail = (byte_position_reg == POS_SATURATED);
        if (!sat_fail)
        begin
            byte_position_next = byte_position_reg + 16'd1;
        end
        len_fail = !(failed_reg || sat_fail) && (byte_position_reg >= HDR_LEN)
                   && ({9'd0, byte_position_reg} >= decl_plus_hdr);

        phase_cur   = (sat_fail || len_fail) ? PH_SINK : phase_reg;
        failed_next = failed_reg || sat_fail || len_fail;

        unique case (phase_cur)
            PH_TYPE:
            begin
                type_is_hello_next = (b == HS_SERVER_HELLO);
                phase_next         = PH_LEN0;
            end
            PH_LEN0:
            begin
                declared_length_next = decl_shift;
                phase_next           = PH_LEN1;
            end
            PH_LEN1:
            begin
                declared_length_next = decl_shift;
                phase_next           = PH_LEN2;
            end
            PH_LEN2:
            begin
                declared_length_next = decl_shift;
                fail                 = (decl_shift > MAX_DECL_LEN);
                phase_next           = PH_VER0;
            end
            PH_VER0:
            begin
                fail       = (b != LEGACY_VER_BYTE);
                phase_next = PH_VER1;
            end
            PH_VER1:
            begin
                fail                 = (b != LEGACY_VER_BYTE);
                phase_next           = PH_RANDOM;
                field_remaining_next = FIELD_LEN;
            end
            PH_RANDOM:
            begin
                res.byte_kind        = KIND_RANDOM;
                res.field_byte       = b;
                res.field_index      = 5'd0 - field_remaining_reg[4:0];
                field_remaining_next = field_dec;
                if (field_dec == 16'd0)
                begin
                    phase_next = PH_SIDLEN;
                end
            end
            PH_SIDLEN:
            begin
                field_remaining_next = {8'd0, b};
                phase_next           = (b != 8'd0) ? PH_SIDSKIP : PH_CS0;
            end
            PH_SIDSKIP:
            begin
                field_remaining_next = field_dec;
                if (field_dec == 16'd0)
                begin
                    phase_next = PH_CS0;
                end
            end
            PH_CS0:
            begin
                fail       = (b != CIPHER_HI);
                phase_next = PH_CS1;
            end
            PH_CS1:
            begin
                fail       = (b != CIPHER_LO);
                phase_next = PH_COMPLEN;
            end
            PH_COMPLEN:
            begin
                fail       = (b != COMP_COUNT);
                phase_next = PH_COMP;
            end
            PH_COMP:
            begin
                fail       = (b != COMP_NULL);
                phase_next = PH_EXTLEN0;
            end
            PH_EXTLEN0:
            begin
                ext_area_next = {b, 8'd0};
                phase_next    = PH_EXTLEN1;
            end
            PH_EXTLEN1:
            begin
                ext_area_next = area_full;
                if (area_full != area_expected)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    phase_next = next_ext(area_full);
                    fail       = (phase_next == PH_SINK);
                end
            end
            PH_ET0:
            begin
                ext_kind_next = {b, 8'd0};
                ext_area_next = area_dec;
                phase_next    = PH_ET1;
            end
            PH_ET1:
            begin
                ext_kind_next = {ext_kind_reg[15:8], b};
                ext_area_next = area_dec;
                phase_next    = PH_ES0;
            end
            PH_ES0:
            begin
                ext_length_next = {b, 8'd0};
                ext_area_next   = area_dec;
                phase_next      = PH_ES1;
            end
            PH_ES1:
            begin
                ext_length_next = ext_len_full;
                ext_area_next   = area_dec;
                priority if (ext_len_full > area_dec)
                begin
                    fail = 1'b1;
                end
                else if (ext_kind_reg == EXT_SUPPORTED_VERSIONS)
                begin
                    fail       = (ext_len_full != SV_BODY_LEN);
                    phase_next = PH_SV0;
                end
                else if (ext_kind_reg == EXT_KEY_SHARE)
                begin
                    fail                 = (ext_len_full < SHARE_HDR_LEN);
                    phase_next           = PH_KSH;
                    field_remaining_next = SHARE_HDR_LEN;
                    share_header_next    = 32'd0;
                end
                else if (ext_len_full == 16'd0)
                begin
                    phase_next = next_ext(area_dec);
                    fail       = (phase_next == PH_SINK);
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SV0:
            begin
                ext_area_next   = area_dec;
                ext_length_next = body_dec;
                fail            = (b != LEGACY_VER_BYTE);
                phase_next      = PH_SV1;
            end
            PH_SV1:
            begin
                ext_area_next   = area_dec;
                ext_length_next = body_dec;
                if (b != TLS13_MINOR)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    seen_version_next = 1'b1;
                    phase_next        = next_ext(area_dec);
                    fail              = (phase_next == PH_SINK);
                end
            end
            PH_KSH:
            begin
                ext_area_next        = area_dec;
                ext_length_next      = body_dec;
                share_header_next    = share_shift;
                field_remaining_next = field_dec;
                if (field_dec == 16'd0)
                begin
                    fail = (share_shift[31:16] != GROUP_X25519)
                           || (share_shift[15:0] != FIELD_LEN)
                           || (body_dec < FIELD_LEN);
                    phase_next           = PH_KEY;
                    field_remaining_next = FIELD_LEN;
                end
            end
            PH_KEY:
            begin
                res.byte_kind        = KIND_KEY;
                res.field_byte       = b;
                res.field_index      = 5'd0 - field_remaining_reg[4:0];
                ext_area_next        = area_dec;
                ext_length_next      = body_dec;
                field_remaining_next = field_dec;
                if (field_dec == 16'd0)
                begin
                    seen_key_share_next = 1'b1;
                    if (body_dec == 16'd0)
                    begin
                        phase_next = next_ext(area_dec);
                        fail       = (phase_next == PH_SINK);
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                ext_area_next   = area_dec;
                ext_length_next = body_dec;
                if (body_dec == 16'd0)
                begin
                    phase_next = next_ext(area_dec);
                    fail       = (phase_next == PH_SINK);
                end
            end
            PH_SINK:
            begin
                phase_next = PH_SINK;
            end
            PH_DONE:
            begin
                fail = 1'b1;
            end
            default:
            begin
                fail = 1'b1;
            end
        endcase

        if (fail || phase_cur == PH_SINK)
        begin
            failed_next = failed_next || fail;
            phase_next  = PH_SINK;
        end

        res.accepted = req.end_of_message && !failed_next && (phase_next == PH_DONE)
                       && seen_version_next && seen_key_share_next && type_is_hello_next;

        if (req.end_of_message)
        begin
            phase_next           = PH_TYPE;
            byte_position_next   = 16'd0;
            declared_length_next = 24'd0;
            field_remaining_next = 16'd0;
            ext_kind_next        = 16'd0;
            ext_length_next      = 16'd0;
            ext_area_next        = 16'd0;
            share_header_next    = 32'd0;
            seen_version_next    = 1'b0;
            seen_key_share_next  = 1'b0;
            type_is_hello_next   = 1'b0;
            failed_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_TYPE;
            byte_position_reg   <= 16'd0;
            declared_length_reg <= 24'd0;
            field_remaining_reg <= 16'd0;
            ext_kind_reg        <= 16'd0;
            ext_length_reg      <= 16'd0;
            ext_area_reg        <= 16'd0;
            share_header_reg    <= 32'd0;
            seen_version_reg    <= 1'b0;
            seen_key_share_reg  <= 1'b0;
            type_is_hello_reg   <= 1'b0;
            failed_reg          <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg           <= phase_next;
            byte_position_reg   <= byte_position_next;
            declared_length_reg <= declared_length_next;
            field_remaining_reg <= field_remaining_next;
            ext_kind_reg        <= ext_kind_next;
            ext_length_reg      <= ext_length_next;
            ext_area_reg        <= ext_area_next;
            share_header_reg    <= share_header_next;
            seen_version_reg    <= seen_version_next;
            seen_key_share_reg  <= seen_key_share_next;
            type_is_hello_reg   <= type_is_hello_next;
            failed_reg          <= failed_next;
        end
    end

    a_fail_sinks: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> phase_reg == PH_SINK)
        else $error("failed flag set outside sink phase");

    a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req.end_of_message |=> phase_reg == PH_TYPE && byte_position_reg == 16'd0)
        else $error("parser did not restart after final byte");

    a_no_emit_failed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.byte_kind != KIND_NONE |-> !failed_reg)
        else $error("field byte emitted after failure");

endmodule

// ===== sv/tls13sh_out_stage.sv =====
// Result register between the parser and the result channel.
// Depends on tls13sh_pkg.
module tls13sh_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  tls13sh_pkg::result_t   res_in,
    output logic                   out_free,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tls13sh_pkg::result_t   res_out
);
    import tls13sh_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    assign out_free       = !out_valid_reg || !result_stall;
    assign out_valid_next = out_free ? advance : out_valid_reg;
    assign result_valid   = out_valid_reg;
    assign res_out        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_in;
        end
    end

    a_accept_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.accepted |-> res_reg.verdict_valid)
        else $error("accept without verdict");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.byte_kind == KIND_NONE || res_reg.byte_kind == KIND_RANDOM
                           || res_reg.byte_kind == KIND_KEY))
        else $error("illegal byte kind in result register");

endmodule

// ===== sv/tls13_server_hello_parser_top.sv =====
// Top level of the ServerHello parser: input register, parser, result register.
// Depends on tls13sh_pkg, tls13sh_in_stage, tls13sh_parse_core, tls13sh_out_stage.
//
//  channel   handshake                  payload
//  request   byte_valid / byte_stall    data_byte, end_of_message
//  result    result_valid / result_stall byte_kind, field_byte, field_index,
//                                       verdict_valid, accepted
//
// One request per cycle unless byte_stall is high, one result per request. A request goes
// from the input register through the combinational parser step into the result register.
// rst_n clears both valid flags and the parser state; the next byte is a message type.
// result_stall holds the result register; byte_stall rises only while it is full and held.
module tls13_server_hello_parser_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] byte_kind,
    output logic [7:0] field_byte,
    output logic [4:0] field_index,
    output logic       verdict_valid,
    output logic       accepted
);
    import tls13sh_pkg::*;

    req_t    req_in;
    req_t    req_q;
    logic    req_valid;
    logic    out_free;
    logic    advance;
    result_t res_d;
    result_t res_q;

    assign req_in.data_byte      = data_byte;
    assign req_in.end_of_message = end_of_message;
    assign advance               = req_valid && out_free;

    tls13sh_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .req_in     (req_in),
        .out_free   (out_free),
        .req_valid  (req_valid),
        .req_out    (req_q)
    );

    tls13sh_parse_core u_parse_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_q),
        .res     (res_d)
    );

    tls13sh_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .res_in       (res_d),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res_out      (res_q)
    );

    assign byte_kind     = res_q.byte_kind;
    assign field_byte    = res_q.field_byte;
    assign field_index   = res_q.field_index;
    assign verdict_valid = res_q.verdict_valid;
    assign accepted      = res_q.accepted;

endmodule

// ===== test/tls13_server_hello_parser_top_tb.sv =====
// Testbench for tls13_server_hello_parser_top: feeds ServerHello byte streams and checks
// every result against a byte-serial parser model of its own.
// Depends on tls13sh_pkg and the RTL of the parser.
`timescale 1ns / 100ps

module tls13_server_hello_parser_top_tb;

    import tls13sh_pkg::*;

    typedef logic [7:0] octet_q[$];

    typedef enum logic [4:0] {
        PS_TYPE, PS_LEN0, PS_LEN1, PS_LEN2, PS_VER0, PS_VER1, PS_RANDOM,
        PS_SIDLEN, PS_SIDSKIP, PS_CS0, PS_CS1, PS_COMPLEN, PS_COMP,
        PS_EXTLEN0, PS_EXTLEN1, PS_ET0, PS_ET1, PS_ES0, PS_ES1, PS_SV0, PS_SV1,
        PS_KSH, PS_KEY, PS_SKIP, PS_DONE, PS_SINK
    } parse_phase_t;

    typedef enum {PART_VERSIONS, PART_KEY_SHARE, PART_OTHER} ext_part_t;

    localparam int unsigned RUN_LIMIT = 8000000;
    localparam int unsigned RANDOM_BYTES = 250;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_message = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [1:0] byte_kind;
    logic [7:0] field_byte;
    logic [4:0] field_index;
    logic       verdict_valid;
    logic       accepted;

    req_t        byte_backlog[$];
    result_t     hello_results_due[$];
    int unsigned tx_gap;
    int unsigned rx_wait;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned hold_clock;
    logic        hold_off;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    parse_phase_t msg_phase;
    logic [15:0]  msg_pos;
    logic [23:0]  msg_decl_len;
    logic [15:0]  msg_left;
    logic [15:0]  msg_ext_code;
    logic [15:0]  msg_ext_left;
    logic [15:0]  msg_area_left;
    logic [31:0]  msg_share_hdr;
    logic         msg_has_version;
    logic         msg_has_key;
    logic         msg_is_hello;
    logic         msg_broken;

    tls13_server_hello_parser_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .byte_kind      (byte_kind),
        .field_byte     (field_byte),
        .field_index    (field_index),
        .verdict_valid  (verdict_valid),
        .accepted       (accepted)
    );

    function automatic void clear_parser();
        msg_phase       = PS_TYPE;
        msg_pos         = '0;
        msg_decl_len    = '0;
        msg_left        = '0;
        msg_ext_code    = '0;
        msg_ext_left    = '0;
        msg_area_left   = '0;
        msg_share_hdr   = '0;
        msg_has_version = 1'b0;
        msg_has_key     = 1'b0;
        msg_is_hello    = 1'b0;
        msg_broken      = 1'b0;
    endfunction

    function automatic void abandon_message();
        msg_broken = 1'b1;
        msg_phase  = PS_SINK;
    endfunction

    function automatic void next_extension();
        if (msg_area_left == 16'd0)
            msg_phase = PS_DONE;
        else if (msg_area_left < EXT_HDR_LEN)
            abandon_message();
        else
            msg_phase = PS_ET0;
    endfunction

    function automatic void count_area_byte();
        if (msg_area_left != 16'd0)
            msg_area_left = msg_area_left - 16'd1;
    endfunction

    function automatic void count_body_byte();
        count_area_byte();
        if (msg_ext_left != 16'd0)
            msg_ext_left = msg_ext_left - 16'd1;
    endfunction

    function automatic void parse_hello_byte(input logic [7:0] b, input logic is_last);
        result_t     due;
        logic [15:0] pos;
        due = '0;
        due.byte_kind = KIND_NONE;
        pos = msg_pos;
        if (pos == POS_SATURATED)
            abandon_message();
        else
            msg_pos = pos + 16'd1;
        if (!msg_broken && pos >= HDR_LEN && 32'(pos) >= 32'(msg_decl_len) + 32'(HDR_LEN))
            abandon_message();
        case (msg_phase)
            PS_TYPE:
            begin
                msg_is_hello = (b == HS_SERVER_HELLO);
                msg_phase = PS_LEN0;
            end
            PS_LEN0:
            begin
                msg_decl_len = {msg_decl_len[15:0], b};
                msg_phase = PS_LEN1;
            end
            PS_LEN1:
            begin
                msg_decl_len = {msg_decl_len[15:0], b};
                msg_phase = PS_LEN2;
            end
            PS_LEN2:
            begin
                msg_decl_len = {msg_decl_len[15:0], b};
                if (msg_decl_len > MAX_DECL_LEN)
                    abandon_message();
                else
                    msg_phase = PS_VER0;
            end
            PS_VER0:
                if (b != LEGACY_VER_BYTE)
                    abandon_message();
                else
                    msg_phase = PS_VER1;
            PS_VER1:
                if (b != LEGACY_VER_BYTE)
                    abandon_message();
                else
                begin
                    msg_phase = PS_RANDOM;
                    msg_left = FIELD_LEN;
                end
            PS_RANDOM:
            begin
                due.byte_kind = KIND_RANDOM;
                due.field_byte = b;
                due.field_index = 5'(FIELD_LEN - msg_left);
                msg_left = msg_left - 16'd1;
                if (msg_left == 16'd0)
                    msg_phase = PS_SIDLEN;
            end
            PS_SIDLEN:
            begin
                msg_left = {8'h00, b};
                msg_phase = (b != 8'h00) ? PS_SIDSKIP : PS_CS0;
            end
            PS_SIDSKIP:
            begin
                msg_left = msg_left - 16'd1;
                if (msg_left == 16'd0)
                    msg_phase = PS_CS0;
            end
            PS_CS0:
                if (b != CIPHER_HI)
                    abandon_message();
                else
                    msg_phase = PS_CS1;
            PS_CS1:
                if (b != CIPHER_LO)
                    abandon_message();
                else
                    msg_phase = PS_COMPLEN;
            PS_COMPLEN:
                if (b != COMP_COUNT)
                    abandon_message();
                else
                    msg_phase = PS_COMP;
            PS_COMP:
                if (b != COMP_NULL)
                    abandon_message();
                else
                    msg_phase = PS_EXTLEN0;
            PS_EXTLEN0:
            begin
                msg_area_left = {b, 8'h00};
                msg_phase = PS_EXTLEN1;
            end
            PS_EXTLEN1:
            begin
                msg_area_left = {msg_area_left[15:8], b};
                if (32'(msg_area_left) !=
                    32'(msg_decl_len) + 32'(HDR_LEN) - (32'(pos) + 32'd1))
                    abandon_message();
                else
                    next_extension();
            end
            PS_ET0:
            begin
                msg_ext_code = {b, 8'h00};
                count_area_byte();
                msg_phase = PS_ET1;
            end
            PS_ET1:
            begin
                msg_ext_code = {msg_ext_code[15:8], b};
                count_area_byte();
                msg_phase = PS_ES0;
            end
            PS_ES0:
            begin
                msg_ext_left = {b, 8'h00};
                count_area_byte();
                msg_phase = PS_ES1;
            end
            PS_ES1:
            begin
                msg_ext_left = {msg_ext_left[15:8], b};
                count_area_byte();
                if (msg_ext_left > msg_area_left)
                    abandon_message();
                else if (msg_ext_code == EXT_SUPPORTED_VERSIONS)
                begin
                    if (msg_ext_left != SV_BODY_LEN)
                        abandon_message();
                    else
                        msg_phase = PS_SV0;
                end
                else if (msg_ext_code == EXT_KEY_SHARE)
                begin
                    if (msg_ext_left < SHARE_HDR_LEN)
                        abandon_message();
                    else
                    begin
                        msg_phase = PS_KSH;
                        msg_left = SHARE_HDR_LEN;
                        msg_share_hdr = '0;
                    end
                end
                else if (msg_ext_left == 16'd0)
                    next_extension();
                else
                    msg_phase = PS_SKIP;
            end
            PS_SV0:
            begin
                count_body_byte();
                if (b != LEGACY_VER_BYTE)
                    abandon_message();
                else
                    msg_phase = PS_SV1;
            end
            PS_SV1:
            begin
                count_body_byte();
                if (b != TLS13_MINOR)
                    abandon_message();
                else
                begin
                    msg_has_version = 1'b1;
                    next_extension();
                end
            end
            PS_KSH:
            begin
                count_body_byte();
                msg_share_hdr = {msg_share_hdr[23:0], b};
                msg_left = msg_left - 16'd1;
                if (msg_left == 16'd0)
                begin
                    if (msg_share_hdr[31:16] != GROUP_X25519 ||
                        msg_share_hdr[15:0] != FIELD_LEN || msg_ext_left < FIELD_LEN)
                        abandon_message();
                    else
                    begin
                        msg_phase = PS_KEY;
                        msg_left = FIELD_LEN;
                    end
                end
            end
            PS_KEY:
            begin
                due.byte_kind = KIND_KEY;
                due.field_byte = b;
                due.field_index = 5'(FIELD_LEN - msg_left);
                count_body_byte();
                msg_left = msg_left - 16'd1;
                if (msg_left == 16'd0)
                begin
                    msg_has_key = 1'b1;
                    if (msg_ext_left == 16'd0)
                        next_extension();
                    else
                        msg_phase = PS_SKIP;
                end
            end
            PS_SKIP:
            begin
                count_body_byte();
                if (msg_ext_left == 16'd0)
                    next_extension();
            end
            PS_SINK:
                ;
            default:
                abandon_message();
        endcase
        due.verdict_valid = is_last;
        due.accepted = is_last && !msg_broken && msg_phase == PS_DONE && msg_has_version &&
                       msg_has_key && msg_is_hello;
        hello_results_due.push_back(due);
        if (is_last)
            clear_parser();
    endfunction

    function automatic void add_random(ref octet_q m, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            m.push_back(8'($urandom));
    endfunction

    function automatic void push16(ref octet_q m, input logic [15:0] v);
        m.push_back(v[15:8]);
        m.push_back(v[7:0]);
    endfunction

    function automatic void make_hello(ref octet_q m, input int unsigned sid_len,
                                       input int unsigned shares, input int unsigned others,
                                       input bit with_version);
        ext_part_t   plan[$];
        int unsigned area_at;
        logic [15:0] n;
        logic [15:0] other_code;
        logic [23:0] hello_len;
        m.delete();
        repeat (4) m.push_back(8'h00);
        m.push_back(LEGACY_VER_BYTE);
        m.push_back(LEGACY_VER_BYTE);
        add_random(m, 32);
        m.push_back(8'(sid_len));
        add_random(m, sid_len);
        m.push_back(CIPHER_HI);
        m.push_back(CIPHER_LO);
        m.push_back(COMP_COUNT);
        m.push_back(COMP_NULL);
        area_at = m.size();
        push16(m, 16'h0000);
        if (with_version)
            plan.push_back(PART_VERSIONS);
        repeat (shares) plan.insert($urandom_range(0, plan.size()), PART_KEY_SHARE);
        repeat (others) plan.insert($urandom_range(0, plan.size()), PART_OTHER);
        foreach (plan[i])
        begin
            case (plan[i])
                PART_VERSIONS:
                begin
                    push16(m, EXT_SUPPORTED_VERSIONS);
                    push16(m, SV_BODY_LEN);
                    m.push_back(LEGACY_VER_BYTE);
                    m.push_back(TLS13_MINOR);
                end
                PART_KEY_SHARE:
                begin
                    n = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 6)) : 16'd0;
                    push16(m, EXT_KEY_SHARE);
                    push16(m, SHARE_HDR_LEN + FIELD_LEN + n);
                    push16(m, GROUP_X25519);
                    push16(m, FIELD_LEN);
                    add_random(m, FIELD_LEN + n);
                end
                default:
                begin
                    do
                        other_code = 16'($urandom);
                    while (other_code == EXT_SUPPORTED_VERSIONS || other_code == EXT_KEY_SHARE);
                    n = 16'($urandom_range(0, 8));
                    push16(m, other_code);
                    push16(m, n);
                    add_random(m, n);
                end
            endcase
        end
        n = 16'(m.size() - area_at - 2);
        m[area_at] = n[15:8];
        m[area_at + 1] = n[7:0];
        hello_len = 24'(m.size() - 4);
        m[0] = HS_SERVER_HELLO;
        m[1] = hello_len[23:16];
        m[2] = hello_len[15:8];
        m[3] = hello_len[7:0];
    endfunction

    function automatic void enqueue_message(ref octet_q m);
        req_t req;
        foreach (m[i])
        begin
            req.data_byte = m[i];
            req.end_of_message = (i == m.size() - 1);
            byte_backlog.push_back(req);
        end
    endfunction

    function automatic int unsigned pause_cycles(input int unsigned seq);
        if ((seq / 150) % 4 == 3 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : fill_backlog
        octet_q      msg;
        int unsigned random_bytes;
        int unsigned pick;
        // short and malformed headers
        msg = '{HS_SERVER_HELLO};
        enqueue_message(msg);
        msg = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        enqueue_message(msg);
        msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        enqueue_message(msg);
        msg = '{HS_SERVER_HELLO, 8'hff, 8'hff, 8'hff, LEGACY_VER_BYTE};
        enqueue_message(msg);
        msg = '{HS_SERVER_HELLO, 8'h00, 8'h00, 8'h26, LEGACY_VER_BYTE, 8'h02};
        enqueue_message(msg);
        // well-formed, then one flaw at a time
        make_hello(msg, 0, 1, 0, 1);
        enqueue_message(msg);
        make_hello(msg, 32, 2, 2, 1);
        enqueue_message(msg);
        make_hello(msg, 255, 1, 1, 1);
        enqueue_message(msg);
        make_hello(msg, 0, 1, 0, 1);
        msg[0] = 8'h01;
        enqueue_message(msg);
        make_hello(msg, 4, 1, 0, 1);
        add_random(msg, 1);
        enqueue_message(msg);
        make_hello(msg, 0, 1, 1, 1);
        repeat (5) void'(msg.pop_back());
        enqueue_message(msg);
        make_hello(msg, 0, 0, 1, 1);
        enqueue_message(msg);
        make_hello(msg, 0, 1, 0, 0);
        enqueue_message(msg);
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            make_hello(msg, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 8),
                       ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 5) == 0) ? 2 : 1),
                       $urandom_range(0, 2), $urandom_range(0, 9) != 0);
            if (pick < 55)
                ;
            else if (pick < 59)
                msg[0] = 8'($urandom);
            else if (pick < 65)
                msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            else if (pick < 71)
                msg[$urandom_range(0, 47) % msg.size()] ^= 8'(1 << $urandom_range(0, 7));
            else if (pick < 77)
                repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            else if (pick < 82)
                add_random(msg, $urandom_range(1, 4));
            else if (pick < 87)
                msg[3] = msg[3] + 8'($urandom_range(1, 3));
            else if (pick < 89)
                msg[1] = 8'($urandom);
            else
            begin
                msg.delete();
                add_random(msg, $urandom_range(1, 40));
            end
            enqueue_message(msg);
            random_bytes += msg.size();
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : request_side
        req_t next_req;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= 8'h00;
            end_of_message <= 1'b0;
            tx_gap <= 0;
            bytes_sent <= 0;
            clear_parser();
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_hello_byte(data_byte, end_of_message);
                bytes_sent <= bytes_sent + 1;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    byte_valid <= 1'b0;
                end
                else if (byte_backlog.size() != 0)
                begin
                    next_req = byte_backlog.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= next_req.data_byte;
                    end_of_message <= next_req.end_of_message;
                    tx_gap <= pause_cycles(bytes_sent);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // hold the result side off for a long stretch so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_clock <= 0;
            hold_off <= 1'b0;
        end
        else
        begin
            hold_clock <= hold_clock + 1;
            hold_off <= (hold_clock >= 1000 && hold_clock < 1400);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_side
        result_t     want;
        int unsigned draw;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (hello_results_due.size() == 0)
                begin
                    $display("%0t: result mismatch, expected none, got kind %0h", $time,
                             byte_kind);
                    mismatch_count++;
                end
                else
                begin
                    want = hello_results_due.pop_front();
                    check_field("byte_kind", 8'(want.byte_kind), 8'(byte_kind));
                    check_field("field_byte", want.field_byte, field_byte);
                    check_field("field_index", 8'(want.field_index), 8'(field_index));
                    check_field("verdict_valid", 8'(want.verdict_valid), 8'(verdict_valid));
                    check_field("accepted", 8'(want.accepted), 8'(accepted));
                end
                results_seen <= results_seen + 1;
                draw = pause_cycles(results_seen);
                rx_wait <= (draw != 0) ? draw - 1 : 0;
                result_stall <= hold_off || draw != 0;
            end
            else
            begin
                if (rx_wait != 0)
                    rx_wait <= rx_wait - 1;
                result_stall <= hold_off || rx_wait != 0;
            end
        end
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tls13_server_hello_parser_top test failed");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        while (byte_backlog.size() != 0 || byte_valid || hello_results_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("tls13_server_hello_parser_top test passed");
        else
            $display("tls13_server_hello_parser_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tls13sh_pkg.sv
sv/tls13sh_in_stage.sv
sv/tls13sh_parse_core.sv
sv/tls13sh_out_stage.sv
sv/tls13_server_hello_parser_top.sv
test/tls13_server_hello_parser_top_tb.sv
